[hdl/mstq_pkg.sv]
package mstq_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        cand;
    logic        better;
    logic        delta;
    logic [31:0] age;
  } rank_t;

endpackage

[hdl/mstq_rank.sv]
module mstq_rank (
  input  logic                 armed,
  input  logic [31:0]          expiry,
  input  logic [31:0]          stamp,
  input  logic [31:0]          cur_time,
  input  logic [31:0]          seq,
  input  logic                 has_best,
  input  logic                 best_dist,
  input  logic [31:0]          best_age,
  output mstq_pkg::rank_t      rank
);

  logic [31:0] delta;
  logic [31:0] age;

  assign delta = expiry - cur_time;
  assign age   = seq - stamp;

  always_comb begin
    rank.cand   = armed && (delta <= 32'd1);
    rank.delta  = delta[0];
    rank.age    = age;
    rank.better = rank.cand &&
                  (!has_best || (rank.delta < best_dist) ||
                   ((rank.delta == best_dist) && (age > best_age)));
  end

endmodule

[hdl/multi_slot_timeout_queue.sv]
// one-shot timeout slots on a 32-bit tick counter that advances when a tick completes
// request channel s_*: s_tuser = kind (start, stop, tick, unused), s_tdata = slot and delay
// result channel m_*: m_tuser = fired, m_tdata = status, fired_slot, slot_pending,
// m_tlast marks the final result of a request
// start arms or re-arms a slot at now + delay (zero delay is rejected),
// stop disarms it, tick reports every armed slot that expires and then advances time
// a start, stop or unused kind is answered in the cycle after acceptance with one result
// a tick scans all slots one per cycle through a single subtract/compare unit;
// each scan pass picks the next slot to report (nearest expiry, then oldest start),
// so a tick that fires n slots makes n scan passes and gives one result per pass, and a tick
// that fires nothing makes a single pass before its single result
// the block takes one request at a time; s_tready is low while a tick is scanned
// results sit in an output register; a new request is taken while it is being
// drained, and a stalled receiver holds the scan at the emit step
// reset clears time, the start counter, all armed flags and the output valid flag
module multi_slot_timeout_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // slot[3:0], delay[35:4], zero[39:36]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // status[0], fired_slot[4:1], slot_pending[5], zero[7:6]
  output logic        m_tuser,   // fired[0]
  output logic        m_tlast
);

  localparam int N = mstq_pkg::NUM_SLOTS;
  localparam int W = mstq_pkg::IDX_W;

  mstq_pkg::state_t state, state_next;

  logic [31:0]  cur_time;
  logic [31:0]  seq;
  logic [N-1:0] armed;
  logic [31:0]  expiry [N];
  logic [31:0]  stamp [N];

  logic [W-1:0] scan_idx;
  logic         has_best;
  logic [W-1:0] best_slot;
  logic         best_dist;
  logic [31:0]  best_age;
  logic         multi;

  logic         o_status;
  logic         o_fired;
  logic [3:0]   o_slot;
  logic         o_pending;
  logic         o_last;

  mstq_pkg::kind_t in_kind;
  logic [3:0]   in_slot;
  logic [31:0]  in_delay;
  logic [W-1:0] in_idx;
  logic         in_valid;
  logic         accept;
  logic         out_free;
  logic         scan_end;
  mstq_pkg::rank_t rank;

  // control
  logic         out_load;
  logic         out_status;
  logic         out_fired;
  logic [3:0]   out_slot;
  logic         out_pending;
  logic         out_last;
  logic         do_start;
  logic         do_stop;
  logic         scan_init;
  logic         scan_step;
  logic         emit_fire;
  logic         time_inc;

  assign in_kind  = mstq_pkg::kind_t'(s_tuser);
  assign in_slot  = s_tdata[3:0];
  assign in_delay = s_tdata[35:4];
  assign in_idx   = W'(in_slot);
  assign in_valid = {28'd0, in_slot} < 32'(N);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == mstq_pkg::ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign scan_end = scan_idx == W'(N - 1);

  mstq_rank u_rank (
    .armed     (armed[scan_idx]),
    .expiry    (expiry[scan_idx]),
    .stamp     (stamp[scan_idx]),
    .cur_time  (cur_time),
    .seq       (seq),
    .has_best  (has_best),
    .best_dist (best_dist),
    .best_age  (best_age),
    .rank      (rank)
  );

  always_comb begin
    state_next  = state;
    out_load    = 1'b0;
    out_status  = 1'b0;
    out_fired   = 1'b0;
    out_slot    = 4'd0;
    out_pending = 1'b0;
    out_last    = 1'b1;
    do_start    = 1'b0;
    do_stop     = 1'b0;
    scan_init   = 1'b0;
    scan_step   = 1'b0;
    emit_fire   = 1'b0;
    time_inc    = 1'b0;
    unique case (state)
      mstq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            mstq_pkg::KIND_START: begin
              out_load = 1'b1;
              if (in_delay == 32'd0) begin
                out_status  = 1'b1;
                out_pending = in_valid && armed[in_idx];
              end else begin
                do_start    = in_valid;
                out_pending = in_valid;
              end
            end
            mstq_pkg::KIND_STOP: begin
              out_load = 1'b1;
              do_stop  = in_valid;
            end
            mstq_pkg::KIND_TICK: begin
              scan_init  = 1'b1;
              state_next = mstq_pkg::ST_SCAN;
            end
            mstq_pkg::KIND_NOP: begin
              out_load    = 1'b1;
              out_pending = in_valid && armed[in_idx];
            end
          endcase
        end
      end
      mstq_pkg::ST_SCAN: begin
        scan_step = 1'b1;
        if (scan_end) begin
          state_next = mstq_pkg::ST_EMIT;
        end
      end
      mstq_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (has_best) begin
            out_fired = 1'b1;
            out_slot  = 4'(best_slot);
            out_last  = !multi;
            emit_fire = 1'b1;
          end
          if (!has_best || !multi) begin
            time_inc   = 1'b1;
            state_next = mstq_pkg::ST_IDLE;
          end else begin
            scan_init  = 1'b1;
            state_next = mstq_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_next = mstq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mstq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time <= 32'd0;
      seq      <= 32'd0;
      armed    <= '0;
      m_tvalid <= 1'b0;
      scan_idx <= '0;
      has_best <= 1'b0;
      multi    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (do_start) begin
        armed[in_idx] <= 1'b1;
        seq           <= seq + 32'd1;
      end
      if (do_stop) begin
        armed[in_idx] <= 1'b0;
      end
      if (emit_fire) begin
        armed[best_slot] <= 1'b0;
      end
      if (time_inc) begin
        cur_time <= cur_time + 32'd1;
      end
      if (scan_init) begin
        scan_idx <= '0;
        has_best <= 1'b0;
        multi    <= 1'b0;
      end else if (scan_step) begin
        scan_idx <= scan_end ? '0 : scan_idx + W'(1);
        if (rank.cand && has_best) begin
          multi <= 1'b1;
        end
        if (rank.better) begin
          has_best <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      expiry[in_idx] <= cur_time + in_delay;
      stamp[in_idx]  <= seq;
    end
    if (scan_step && rank.better) begin
      best_slot <= scan_idx;
      best_dist <= rank.delta;
      best_age  <= rank.age;
    end
    if (out_load) begin
      o_status  <= out_status;
      o_fired   <= out_fired;
      o_slot    <= out_slot;
      o_pending <= out_pending;
      o_last    <= out_last;
    end
  end

  assign m_tdata = {2'b00, o_pending, o_slot, o_status};
  assign m_tuser = o_fired;
  assign m_tlast = o_last;

  // time moves only when a tick delivers its final result
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (cur_time != $past(cur_time))) |-> $past(time_inc))
    else $error("time advanced outside tick completion");

  // an accepted nonzero start on a real slot bumps the start counter by one
  assert property (@(posedge clk) disable iff (rst)
    (accept && (in_kind == mstq_pkg::KIND_START) && (in_delay != 32'd0) && in_valid)
    |=> (seq == $past(seq) + 32'd1))
    else $error("start counter not advanced");

  // a reported slot was armed when picked and is disarmed afterwards
  assert property (@(posedge clk) disable iff (rst)
    emit_fire |-> armed[best_slot])
    else $error("reporting a slot that is not armed");

  assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> !armed[$past(best_slot)])
    else $error("fired slot still armed");

endmodule

[verif/multi_slot_timeout_queue_test.sv]
module multi_slot_timeout_queue_test;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned RANDOM_REQUESTS = 73;
  localparam int unsigned DRAIN_CYCLES = 2 * (mstq_pkg::NUM_SLOTS + 1) + 20;

  typedef struct packed {
    mstq_pkg::kind_t kind;
    logic [3:0]      slot;
    logic [31:0]     delay;
  } timer_req_t;

  typedef struct packed {
    logic       status;
    logic       fired;
    logic [3:0] fired_slot;
    logic       slot_pending;
    logic       last;
  } timer_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // slot[3:0], delay[35:4], zero[39:36]
  logic [1:0]  s_tuser = '0;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // status[0], fired_slot[4:1], slot_pending[5], zero[7:6]
  logic        m_tuser;        // fired[0]
  logic        m_tlast;

  multi_slot_timeout_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timer state mirrored for prediction
  logic [31:0] model_time = '0;
  logic [31:0] arm_count = '0;
  logic [31:0] deadline [mstq_pkg::NUM_SLOTS];
  logic [31:0] arm_order [mstq_pkg::NUM_SLOTS];
  logic        armed [mstq_pkg::NUM_SLOTS];

  timer_req_t  pending_requests [$];
  timer_res_t  expected_results [$];
  timer_req_t  active_req;

  int unsigned requests_total = 0;
  int unsigned requests_taken = 0;
  int unsigned results_seen = 0;
  int unsigned starts_seen = 0;
  int unsigned stops_seen = 0;
  int unsigned ticks_seen = 0;
  int unsigned others_seen = 0;
  int unsigned expiries_seen = 0;
  int unsigned fault_count = 0;
  int unsigned fault_reports = 0;
  int unsigned cycle_count = 0;

  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned hold_left = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_started = 1'b0;

  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // nearer expiry first, then the older start
  function automatic bit reports_first(input int unsigned a, input int unsigned b);
    logic [31:0] dist_a, dist_b, age_a, age_b;
    dist_a = deadline[a] - model_time;
    dist_b = deadline[b] - model_time;
    age_a = arm_count - arm_order[a];
    age_b = arm_count - arm_order[b];
    if (dist_a != dist_b) return dist_a < dist_b;
    return age_a > age_b;
  endfunction

  task automatic predict_timer_results(input timer_req_t req);
    timer_res_t  res;
    int unsigned fire_list [mstq_pkg::NUM_SLOTS];
    int unsigned n;
    int unsigned j;
    logic [31:0] delta;
    bit          in_range;
    res = '0;
    res.last = 1'b1;
    n = 0;
    in_range = (req.slot < mstq_pkg::NUM_SLOTS);
    case (req.kind)
      mstq_pkg::KIND_START: begin
        starts_seen++;
        if (req.delay == 32'd0) begin
          res.status = 1'b1;
          res.slot_pending = in_range ? armed[req.slot] : 1'b0;
        end else if (in_range) begin
          deadline[req.slot] = model_time + req.delay;
          arm_order[req.slot] = arm_count;
          armed[req.slot] = 1'b1;
          arm_count = arm_count + 32'd1;
          res.slot_pending = 1'b1;
        end
        expected_results.push_back(res);
      end
      mstq_pkg::KIND_STOP: begin
        stops_seen++;
        if (in_range) armed[req.slot] = 1'b0;
        expected_results.push_back(res);
      end
      mstq_pkg::KIND_TICK: begin
        ticks_seen++;
        for (int i = 0; i < mstq_pkg::NUM_SLOTS; i++) begin
          delta = deadline[i] - model_time;
          if (armed[i] && delta <= 32'd1) begin
            j = n;
            while (j > 0 && reports_first(i, fire_list[j - 1])) begin
              fire_list[j] = fire_list[j - 1];
              j--;
            end
            fire_list[j] = i;
            n++;
          end
        end
        for (int k = 0; k < n; k++) begin
          armed[fire_list[k]] = 1'b0;
          res = '0;
          res.fired = 1'b1;
          res.fired_slot = 4'(fire_list[k]);
          res.last = (k + 1 == n);
          expected_results.push_back(res);
          expiries_seen++;
        end
        model_time = model_time + 32'd1;
        if (n == 0) expected_results.push_back(res);
      end
      default: begin
        others_seen++;
        res.slot_pending = in_range ? armed[req.slot] : 1'b0;
        expected_results.push_back(res);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_timer_results(active_req);
        requests_taken++;
        tx_gap = pick_gap(tx_burst);
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          active_req = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= active_req.kind;
          s_tdata <= {4'b0000, active_req.delay, active_req.slot};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    timer_res_t got;
    timer_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.status = m_tdata[0];
        got.fired = m_tuser;
        got.fired_slot = m_tdata[4:1];
        got.slot_pending = m_tdata[5];
        got.last = m_tlast;
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_reports < 10) begin
            fault_reports++;
            $display("unexpected result: status %0b fired %0b slot %0d pending %0b last %0b",
                     got.status, got.fired, got.fired_slot, got.slot_pending, got.last);
          end
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_reports < 10) begin
              fault_reports++;
              $display("result %0d expected status %0b fired %0b slot %0d pending %0b last %0b",
                       results_seen, want.status, want.fired, want.fired_slot,
                       want.slot_pending, want.last);
              $display("  actual status %0b fired %0b slot %0d pending %0b last %0b",
                       got.status, got.fired, got.fired_slot, got.slot_pending, got.last);
            end
          end
        end
        rx_stall = pick_gap(rx_burst);
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      end
      if (hold_request && !hold_started) begin
        hold_started = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_request(input mstq_pkg::kind_t kind, input logic [3:0] slot,
                               input logic [31:0] delay);
    timer_req_t req;
    req.kind = kind;
    req.slot = slot;
    req.delay = delay;
    pending_requests.push_back(req);
    requests_total++;
  endtask

  task automatic queue_random_request();
    int unsigned pick;
    logic [31:0] delay;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 7) delay = $urandom_range(1, 6);
    else if ($urandom_range(0, 2) == 0) delay = 32'd0;
    else delay = $urandom;
    if (pick < 40) queue_request(mstq_pkg::KIND_START, 4'($urandom_range(0, 15)), delay);
    else if (pick < 55) queue_request(mstq_pkg::KIND_STOP, 4'($urandom_range(0, 15)), $urandom);
    else if (pick < 95) queue_request(mstq_pkg::KIND_TICK, 4'($urandom_range(0, 15)), $urandom);
    else queue_request(mstq_pkg::KIND_NOP, 4'($urandom_range(0, 15)), $urandom);
  endtask

  initial begin
    int unsigned slot_perm [$];
    int unsigned idx;
    int unsigned tmp;

    for (int i = 0; i < mstq_pkg::NUM_SLOTS; i++) begin
      armed[i] = 1'b0;
      deadline[i] = '0;
      arm_order[i] = '0;
    end

    // directed opening
    queue_request(mstq_pkg::KIND_TICK, 4'd0, 32'd0);
    queue_request(mstq_pkg::KIND_START, 4'd0, 32'd0);
    queue_request(mstq_pkg::KIND_START, 4'd3, 32'd1);
    queue_request(mstq_pkg::KIND_START, 4'd15, 32'hffff_ffff);
    queue_request(mstq_pkg::KIND_START, 4'd5, 32'd2);
    queue_request(mstq_pkg::KIND_START, 4'd7, 32'd2);
    queue_request(mstq_pkg::KIND_START, 4'd5, 32'd2);
    queue_request(mstq_pkg::KIND_START, 4'd5, 32'd0);
    queue_request(mstq_pkg::KIND_NOP, 4'd5, 32'd0);
    queue_request(mstq_pkg::KIND_NOP, 4'd9, 32'hffff_ffff);
    queue_request(mstq_pkg::KIND_STOP, 4'd15, 32'd0);
    queue_request(mstq_pkg::KIND_STOP, 4'd9, 32'hffff_ffff);
    queue_request(mstq_pkg::KIND_TICK, 4'd15, 32'hffff_ffff);
    queue_request(mstq_pkg::KIND_TICK, 4'd0, 32'd0);
    queue_request(mstq_pkg::KIND_START, 4'd0, 32'h8000_0000);
    queue_request(mstq_pkg::KIND_START, 4'd12, 32'h7fff_ffff);
    queue_request(mstq_pkg::KIND_START, 4'd10, 32'd3);
    queue_request(mstq_pkg::KIND_STOP, 4'd10, 32'd0);
    queue_request(mstq_pkg::KIND_TICK, 4'd0, 32'd0);
    queue_request(mstq_pkg::KIND_TICK, 4'd0, 32'd0);

    // random traffic with one burst that fires every slot on the same tick
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 40) begin
        slot_perm.delete();
        for (int s = 0; s < mstq_pkg::NUM_SLOTS; s++) slot_perm.push_back(s);
        for (int s = mstq_pkg::NUM_SLOTS - 1; s > 0; s--) begin
          idx = $urandom_range(0, s);
          tmp = slot_perm[s];
          slot_perm[s] = slot_perm[idx];
          slot_perm[idx] = tmp;
        end
        foreach (slot_perm[s]) queue_request(mstq_pkg::KIND_START, 4'(slot_perm[s]), 32'd2);
        queue_request(mstq_pkg::KIND_TICK, 4'd0, 32'd0);
        queue_request(mstq_pkg::KIND_TICK, 4'd0, 32'd0);
      end else begin
        queue_random_request();
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (requests_taken < 35) @(negedge clk);
    hold_request = 1'b1;

    while (requests_taken < requests_total || expected_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() > 0) begin
      fault_count += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("covered %0d requests: %0d starts, %0d stops, %0d ticks, %0d unused kind",
             requests_taken, starts_seen, stops_seen, ticks_seen, others_seen);
    $display("checked %0d results including %0d slot expiries, %0d faults",
             results_seen, expiries_seen, fault_count);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
hdl/mstq_pkg.sv
hdl/mstq_rank.sv
hdl/multi_slot_timeout_queue.sv
verif/multi_slot_timeout_queue_test.sv
